FILE: rtl/orbit_position_generator_top_assert.svh
// ----------------------------------------------------------------------------
// Orbit generator assertion macros
// Shared concurrent assertion forms for the orbit generator RTL.
// ----------------------------------------------------------------------------
`ifndef ORBIT_POSITION_GENERATOR_TOP_ASSERT_SVH
`define ORBIT_POSITION_GENERATOR_TOP_ASSERT_SVH

// antecedent implies consequent on the next clock
`define OPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition holds at every clock out of reset
`define OPG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: rtl/opg_pkg.sv
// ----------------------------------------------------------------------------
// Orbit generator package
// Shared constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package opg_pkg;

    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);

    localparam logic [31:0] GoldenBam = 32'h61C8_8647;
    localparam logic [31:0] CordicGain = 32'd652032874;

    localparam logic [1:0] OP_NOTE_ON = 2'd0;
    localparam logic [1:0] OP_UPDATE  = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [2:0] REG_BASE_RADIUS  = 3'd0;
    localparam logic [2:0] REG_VEL_RADIUS   = 3'd1;
    localparam logic [2:0] REG_ORBIT_RATE   = 3'd2;
    localparam logic [2:0] REG_AT_WIDEN     = 3'd3;
    localparam logic [2:0] REG_ORBIT_HEIGHT = 3'd4;
    localparam logic [2:0] REG_RELEASE_SLOW = 3'd5;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            default: v = 32'h00000001;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

FILE: rtl/opg_cordic.sv
// ----------------------------------------------------------------------------
// Orbit generator CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, Q2.30 sin and cos.
// ----------------------------------------------------------------------------
module opg_cordic (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [31:0]         phase,
    output logic                done,
    output logic signed [33:0]  cos_out,
    output logic signed [33:0]  sin_out
);
    import opg_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic               busy_reg, busy_next;
    logic [StepW-1:0]   step_reg, step_next;
    logic signed [33:0] dx, dy, ang, pa, pf;

    assign dx = x_reg >>> step_reg;
    assign dy = y_reg >>> step_reg;
    assign ang = {2'b00, atan_bam(5'(step_reg))};
    assign pa  = 34'(signed'(phase));
    assign pf  = 34'(signed'(phase - 32'h8000_0000));

    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        flip_next = flip_reg; busy_next = busy_reg; step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            x_next = {2'b00, CordicGain};
            y_next = '0;
            flip_next = (pa > 34'sh4000_0000) || (pa < -34'sh4000_0000);
            z_next = flip_next ? pf : pa;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - dy; y_next = y_reg + dx; z_next = z_reg - ang;
            end else begin
                x_next = x_reg + dy; y_next = y_reg - dx; z_next = z_reg + ang;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(CordicSteps - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        flip_reg <= flip_next;
    end

    assign done    = busy_reg && (step_reg == StepW'(CordicSteps - 1));
    assign cos_out = flip_reg ? -x_next : x_next;
    assign sin_out = flip_reg ? -y_next : y_next;

`include "orbit_position_generator_top_assert.svh"
    `OPG_ASSERT_NEXT(a_cordic_idle, aclk, aresetn, done, !busy_reg, "cordic still busy")
    `OPG_ASSERT_ALWAYS(a_cordic_step, aclk, aresetn, step_reg <= StepW'(CordicSteps), "step overrun")
    `OPG_ASSERT_NEXT(a_cordic_start, aclk, aresetn, start, busy_reg && step_reg == '0, "bad start")

endmodule

FILE: rtl/orbit_position_generator_top.sv
// ----------------------------------------------------------------------------
// Orbit position generator
// One voice of a circular orbit: phase accumulator plus CORDIC sin/cos.
// ----------------------------------------------------------------------------
// Note on / update, from accept to m_tvalid: 3 multiply steps, CORDIC load,
//   16 CORDIC rotations, 2 scale steps, then the output waits for m_tready.
// One item at a time: a release passes through the REL state and an unused
//   code is accepted and dropped in idle. s_tready low while busy.
// Reset (aresetn low, synchronous): registers back to defaults, state zero.
module orbit_position_generator_top (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tuser: operation[1:0]
    // s_tdata: note_number[6:0], note_velocity[22:7], aftertouch_level[38:23],
    //          time_delta[62:39], center_x[94:63], center_y[126:95],
    //          center_z[158:127], zero pad to 160
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic [1:0]   s_tuser,
    // m_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import opg_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_REL = 4'd1, ST_M1 = 4'd2, ST_M2 = 4'd3,
                           ST_M3 = 4'd4, ST_CSTART = 4'd5, ST_CWAIT = 4'd6,
                           ST_SC1 = 4'd7, ST_SC2 = 4'd8, ST_OUT = 4'd9;

    logic [30:0] base_radius_reg, vel_radius_reg;
    logic [31:0] orbit_rate_reg, orbit_height_reg;
    logic [23:0] at_widen_reg;
    logic [16:0] release_slow_reg;

    logic [31:0] phase_reg, speed_reg, radius_reg;
    logic [3:0]  state_reg, state_next;
    logic [159:0] in_reg;
    logic [1:0]  op_reg;
    logic [40:0] r_reg;
    logic [24:0] f_reg;
    logic signed [33:0] c_reg, s_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;

    // one shared multiplier: 33-bit signed by 33-bit signed
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [1:0] op;
    assign op = op_reg;

    logic cdone, cstart;
    logic signed [33:0] ccos, csin;
    assign cstart = (state_reg == ST_CSTART);

    opg_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .phase(phase_reg),
        .done(cdone), .cos_out(ccos), .sin_out(csin)
    );

    // scale r by a Q2.30 value, truncating toward zero; r split in two halves
    logic signed [33:0] sc_t;
    logic [33:0]        sc_m;
    logic [57:0]        sc_hi, sc_lo;
    logic [63:0]        sc_q;
    logic signed [63:0] sc_v, sum_v;
    logic signed [31:0] sc_cen;
    assign sc_t = (state_reg == ST_SC1) ? c_reg : s_reg;
    assign sc_cen = (state_reg == ST_SC1) ? signed'(in_reg[94:63]) : signed'(in_reg[158:127]);
    assign sc_m = sc_t[33] ? 34'(-sc_t) : 34'(sc_t);
    assign sc_hi = 58'(r_reg[40:16]) * 58'(sc_m[31:0]);
    assign sc_lo = 58'(r_reg[15:0]) * 58'(sc_m[31:0]);
    assign sc_q = 64'((sc_hi + (sc_lo >> 16)) >> 14);
    assign sc_v = sc_t[33] ? -signed'(sc_q) : signed'(sc_q);
    assign sum_v = 64'(sc_cen) + sc_v;

    always_comb begin
        mul_a = '0; mul_b = '0;
        unique case (state_reg)
            ST_REL: begin
                mul_a = 33'(signed'(speed_reg)); mul_b = signed'({16'd0, release_slow_reg});
            end
            ST_M1: begin
                if (op == OP_NOTE_ON) begin
                    mul_a = signed'({2'b0, vel_radius_reg}); mul_b = signed'({17'd0, in_reg[22:7]});
                end else begin
                    mul_a = 33'(signed'(speed_reg)); mul_b = signed'({9'd0, in_reg[62:39]});
                end
            end
            ST_M2: begin
                mul_a = signed'({9'd0, at_widen_reg}); mul_b = signed'({17'd0, in_reg[38:23]});
            end
            ST_M3: begin
                mul_a = signed'({1'b0, radius_reg}); mul_b = signed'({8'd0, f_reg});
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) begin
                if (s_tuser == OP_RELEASE) state_next = ST_REL;
                else if (s_tuser == OP_NOTE_ON || s_tuser == OP_UPDATE)
                    state_next = ST_M1;
            end
            ST_REL:    state_next = ST_IDLE;
            ST_M1:     state_next = ST_M2;
            ST_M2:     state_next = ST_M3;
            ST_M3:     state_next = ST_CSTART;
            ST_CSTART: state_next = ST_CWAIT;
            ST_CWAIT:  if (cdone) state_next = ST_SC1;
            ST_SC1:    state_next = ST_SC2;
            ST_SC2:    state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {pz_reg, py_reg, px_reg};

    logic signed [65:0] rel_v;
    assign rel_v = (mul_p + 66'sd32768) >>> 16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            base_radius_reg  <= 31'd65536;
            vel_radius_reg   <= '0;
            orbit_rate_reg   <= 32'd16777216;
            at_widen_reg     <= '0;
            orbit_height_reg <= '0;
            release_slow_reg <= 17'd65536;
            phase_reg        <= '0;
            speed_reg        <= '0;
            radius_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_BASE_RADIUS:  base_radius_reg  <= cfg_data[30:0];
                    REG_VEL_RADIUS:   vel_radius_reg   <= cfg_data[30:0];
                    REG_ORBIT_RATE:   orbit_rate_reg   <= cfg_data;
                    REG_AT_WIDEN:     at_widen_reg     <= cfg_data[23:0];
                    REG_ORBIT_HEIGHT: orbit_height_reg <= cfg_data;
                    REG_RELEASE_SLOW: release_slow_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_REL: speed_reg <= sat32(64'(rel_v));
                ST_M1: begin
                    if (op == OP_NOTE_ON) begin
                        phase_reg  <= 32'(in_reg[6:0] * GoldenBam);
                        speed_reg  <= orbit_rate_reg;
                        radius_reg <= 32'({1'b0, base_radius_reg} + 32'(mul_p[62:16]));
                    end else begin
                        phase_reg <= phase_reg + mul_p[47:16];
                    end
                end
                default: ;
            endcase
        end
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata;
            op_reg <= s_tuser;
        end
        if (state_reg == ST_M2) f_reg <= 25'd65536 + 25'(mul_p[39:16]);
        if (state_reg == ST_M3) r_reg <= mul_p[56:16];
        if (state_reg == ST_CWAIT && cdone) begin
            c_reg <= ccos; s_reg <= csin;
        end
        if (state_reg == ST_SC1) begin
            px_reg <= sat32(sum_v);
            py_reg <= sat32(64'(signed'(in_reg[126:95])) + 64'(signed'(orbit_height_reg)));
        end
        if (state_reg == ST_SC2) pz_reg <= sat32(sum_v);
    end

`include "orbit_position_generator_top_assert.svh"
    `OPG_ASSERT_NEXT(a_accept_busy, aclk, aresetn,
        s_tvalid && s_tready && s_tuser != OP_UNUSED, !s_tready, "accepted but still ready")
    `OPG_ASSERT_ALWAYS(a_out_excl, aclk, aresetn, !(m_tvalid && s_tready), "output and input overlap")
    `OPG_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit position generator testbench
// Drives note on, update, release and unused items through the stream port, predicts
// each emitted position with a bit-true CORDIC orbit predictor and checks it.
// ----------------------------------------------------------------------------

// Expected-position store plus the orbit predictor.
class orbit_scoreboard;
    logic [30:0] base_radius, velocity_radius;
    logic [31:0] orbit_rate, orbit_height;
    logic [23:0] aftertouch_widen;
    logic [16:0] release_slow;
    logic [31:0] phase, speed, note_radius;
    logic [95:0] expected_pos[$];
    int mismatches;
    int positions_checked;

    function void reset_state();
        base_radius = 31'd65536; velocity_radius = '0; orbit_rate = 32'd16777216;
        aftertouch_widen = '0; orbit_height = '0; release_slow = 17'd65536;
        phase = '0; speed = '0; note_radius = '0;
        expected_pos.delete(); mismatches = 0; positions_checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            opg_pkg::REG_BASE_RADIUS:  base_radius = val[30:0];
            opg_pkg::REG_VEL_RADIUS:   velocity_radius = val[30:0];
            opg_pkg::REG_ORBIT_RATE:   orbit_rate = val;
            opg_pkg::REG_AT_WIDEN:     aftertouch_widen = val[23:0];
            opg_pkg::REG_ORBIT_HEIGHT: orbit_height = val;
            opg_pkg::REG_RELEASE_SLOW: release_slow = val[16:0];
            default: ;
        endcase
    endfunction

    function logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // r (Q16.16, up to 41 bits) times t (Q2.30), truncated toward zero
    function longint radius_times(longint unsigned r, longint t);
        longint unsigned m, q;
        m = (t < 0) ? longint'(-t) : t;
        q = ((r >> 16) * m + (((r & 64'hFFFF) * m) >> 16)) >> 14;
        return (t < 0) ? -longint'(q) : longint'(q);
    endfunction

    function logic [95:0] position(logic [159:0] d);
        logic [31:0] atan_tab[16];
        longint unsigned f, r;
        longint x, y, z, dx, dy, a;
        bit flip;
        atan_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                     32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                     32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                     32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
        f = 65536 + ((longint'(aftertouch_widen) * longint'(d[38:23])) >> 16);
        r = (longint'(note_radius) * f) >> 16;
        a = longint'($signed(phase));
        flip = (a > 64'sh40000000) || (a < -64'sh40000000);
        if (flip) a = longint'($signed(phase - 32'h80000000));
        x = 652032874; y = 0; z = a;
        for (int i = 0; i < 16; i++) begin
            dx = x >>> i; dy = y >>> i;
            if (z >= 0) begin
                x -= dy; y += dx; z -= longint'(atan_tab[i]);
            end else begin
                x += dy; y -= dx; z += longint'(atan_tab[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        return {clamp32(longint'($signed(d[158:127])) + radius_times(r, y)),
                clamp32(longint'($signed(d[126:95])) + longint'($signed(orbit_height))),
                clamp32(longint'($signed(d[94:63])) + radius_times(r, x))};
    endfunction

    function void note_input(logic [1:0] op, logic [159:0] d);
        longint p;
        case (op)
            opg_pkg::OP_NOTE_ON: begin
                phase = 32'(d[6:0] * opg_pkg::GoldenBam);
                speed = orbit_rate;
                note_radius = 32'(longint'(base_radius)
                              + ((longint'(velocity_radius) * longint'(d[22:7])) >> 16));
                expected_pos.push_back(position(d));
            end
            opg_pkg::OP_UPDATE: begin
                p = longint'($signed(speed)) * longint'(d[62:39]);
                phase += p[47:16];
                expected_pos.push_back(position(d));
            end
            opg_pkg::OP_RELEASE: begin
                p = longint'($signed(speed)) * longint'(release_slow);
                speed = clamp32((p + 32768) >>> 16);
            end
            default: ;
        endcase
    endfunction

    function void check_position(logic [95:0] got);
        logic [95:0] want;
        if (expected_pos.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected position transfer %h", got);
            return;
        end
        want = expected_pos.pop_front();
        positions_checked++;
        for (int k = 0; k < 3; k++) begin
            if (got[32*k +: 32] !== want[32*k +: 32]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pos field %0d: expected %h got %h", k,
                             want[32*k +: 32], got[32*k +: 32]);
            end
        end
    endfunction
endclass

module tb;
    import opg_pkg::*;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
    logic [159:0] s_tdata;
    logic [1:0] s_tuser;
    logic [95:0] m_tdata;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    orbit_scoreboard sb;
    int send_idle_pct, recv_idle_pct; // percent of cycles each side idles
    bit hold_recv;                   // long receiver hold-off request
    int quiet_cycles;

    orbit_position_generator_top u_dut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // Input items and results are sampled at the clock edge; the scoreboard
    // learns of an input only once its transfer happens.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_position(m_tdata);
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles with no transfer on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else if (quiet_cycles >= 20000) begin
            $display("orbit_position_generator_top test failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(logic [1:0] op, logic [6:0] note, logic [15:0] vel,
                             logic [15:0] at, logic [23:0] dt,
                             logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, cz, cy, cx, dt, at, vel, note};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic rand_item(logic [1:0] op);
        send_item(op, 7'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                  $urandom_range(3) == 0 ? $urandom : 32'(int'($urandom_range(2000000)) - 1000000),
                  $urandom, $urandom_range(3) == 0 ? $urandom : $urandom_range(65535));
    endtask

    // Idle point: every expected position in, then let a release finish.
    task automatic drain();
        while (sb.expected_pos.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic random_regs(bit extreme);
        write_reg(REG_BASE_RADIUS, extreme ? 32'h7FFFFFFF : $urandom_range(32'h01000000));
        write_reg(REG_VEL_RADIUS, extreme ? 32'h7FFFFFFF : $urandom_range(32'h00400000));
        write_reg(REG_ORBIT_RATE, extreme ? 32'h80000000 : $urandom);
        write_reg(REG_AT_WIDEN, extreme ? 32'hFFFFFF : $urandom_range(32'h3FFFF));
        write_reg(REG_ORBIT_HEIGHT, extreme ? 32'h7FFFFFFF : $urandom);
        write_reg(REG_RELEASE_SLOW, extreme ? 32'h1FFFF : $urandom_range(65536));
    endtask

    initial begin
        logic [1:0] op;
        sb = new();
        sb.reset_state();
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tuser = '0; cfg_valid = 0; cfg_index = '0;
        cfg_data = '0; hold_recv = 0; send_idle_pct = 17; recv_idle_pct = 70;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: update before any note gives the centre plus height.
        send_item(OP_UPDATE, '0, '0, '0, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, '0);
        send_item(OP_NOTE_ON, '0, '0, '0, '0, '0, '0, '0);
        send_item(OP_NOTE_ON, 7'd127, 16'hFFFF, 16'hFFFF, '0, 32'h80000000, '0, 32'h7FFFFFFF);
        send_item(OP_UNUSED, 7'd127, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, '1, '1, '1);
        send_item(OP_UPDATE, '0, '0, 16'hFFFF, 24'hFFFFFF, '0, '0, '0);
        send_item(OP_RELEASE, '0, '0, '0, '0, '0, '0, '0);
        send_item(OP_UPDATE, '0, '0, '0, 24'h800000, '0, '0, '0);
        drain();
        random_regs(1);  // maximum radius, most negative rate, slow above one
        send_item(OP_NOTE_ON, 7'd127, 16'hFFFF, 16'hFFFF, '0, '0, 32'h7FFFFFFF, '0);
        repeat (3) send_item(OP_RELEASE, '0, '0, '0, '0, '0, '0, '0); // speed saturates
        send_item(OP_UPDATE, 7'd5, '0, 16'hFFFF, 24'hFFFFFF, 32'h80000000, '0, 32'h80000000);
        send_item(OP_UPDATE, '0, '0, '0, 24'h123456, '0, 32'h80000000, '0);
        drain();
        write_reg(3'd7, 32'hFFFFFFFF); // out-of-range index is ignored

        for (int phase_n = 0; phase_n < 3; phase_n++) begin
            send_idle_pct = (phase_n == 0) ? 17 : (phase_n == 1) ? 70 : 0;
            recv_idle_pct = (phase_n == 0) ? 70 : (phase_n == 1) ? 17 : 0;
            drain();
            random_regs(0);
            if (phase_n == 2) write_reg(REG_RELEASE_SLOW, 32'd0);
            for (int n = 0; n < 230; n++) begin
                if (n == 100) begin
                    // long receiver hold-off while items keep coming
                    fork
                        begin
                            hold_recv = 1;
                            repeat (400) @(posedge aclk);
                            hold_recv = 0;
                        end
                    join_none
                end
                if (n == 180) drain();
                // mostly note followed by updates, sometimes a release or an unused code
                if (n % 12 == 0) op = OP_NOTE_ON;
                else begin
                    op = ($urandom_range(9) == 0) ? OP_RELEASE : OP_UPDATE;
                    if ($urandom_range(49) == 0) op = OP_UNUSED;
                end
                rand_item(op);
            end
        end

        while (sb.expected_pos.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Covered note on, update, release and unused items under three stall mixes,");
        $display("%0d positions checked with register extremes and a long output stall.",
                 sb.positions_checked);
        if (sb.mismatches == 0 && sb.expected_pos.size() == 0)
            $display("orbit_position_generator_top test passed");
        else
            $display("orbit_position_generator_top test failed");
        $finish;
    end
endmodule
